[design/pwd_pkg.sv]
// Shared types and constants of the pairwise distance core.
`timescale 1ns / 1ps
package pwd_pkg;

   localparam int ELEM_W     = 16;
   localparam int ROWS_REG_W = 7;
   localparam int COLS_REG_W = 11;
   localparam int CSR_DATA_W = 11;
   localparam int OUT_ROW_W  = 6;
   localparam int DIST_W     = 21;
   localparam int SQ_W       = 32;
   localparam logic [DIST_W-1:0] DIST_MAX = '1;

   typedef enum logic [0:0] {
      CSR_ROWS_IN_USE    = 1'b0,
      CSR_COLUMNS_IN_USE = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_EMIT,
      ST_ROOT
   } state_type;

   // What a cell does with the sum handed over by its neighbor on a shift.
   typedef struct packed {
      logic shift;
      logic clear;
      logic add;
   } cell_op_type;

endpackage

[design/pwd_row_store.sv]
// Row store: one write port and one registered read port.
`timescale 1ns / 1ps
module pwd_row_store
   import pwd_pkg::*;
#(
   parameter int ADDR_W = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [ADDR_W-1:0]        wr_addr,
   input  logic signed [ELEM_W-1:0] wr_data,
   input  logic                     rd_en,
   input  logic [ADDR_W-1:0]        rd_addr,
   output logic signed [ELEM_W-1:0] rd_data
);

   logic signed [ELEM_W-1:0] mem_ff [2**ADDR_W];
   logic signed [ELEM_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/pwd_sum_cell.sv]
// One accumulator cell of the rotating chain of running sums.
`timescale 1ns / 1ps
module pwd_sum_cell
   import pwd_pkg::*;
#(
   parameter int SUM_W = 42
) (
   input  logic             clock,
   input  cell_op_type      op,
   input  logic [SUM_W-1:0] nb_sum,
   input  logic [SUM_W-1:0] addend,
   output logic [SUM_W-1:0] sum
);

   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;

   always_comb begin
      sum_in = (op.clear ? '0 : nb_sum) + (op.add ? addend : '0);
   end

   always_ff @(posedge clock) begin
      if (op.shift) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

[design/pwd_isqrt.sv]
// Bit-serial floor square root, one root bit per cycle, saturated to the output width.
`timescale 1ns / 1ps
module pwd_isqrt
   import pwd_pkg::*;
#(
   parameter int SUM_W = 42
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  operand,
   output logic              done,
   output logic [DIST_W-1:0] root
);

   localparam int RW    = (SUM_W + 1) / 2;
   localparam int VW    = 2 * RW;
   localparam int CNT_W = $clog2(RW + 1);

   logic [VW-1:0]    val_ff, val_in;
   logic [RW+1:0]    rem_ff, rem_in;
   logic [RW-1:0]    root_ff, root_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [RW+1:0]         rem_sh;
   logic [RW+1:0]         trial;
   logic [RW+DIST_W-1:0]  root_ext;

   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      rem_sh  = {rem_ff[RW-1:0], val_ff[VW-1 -: 2]};
      trial   = {root_ff, 2'b01};
      if (start) begin
         val_in  = VW'(operand);
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         val_in = {val_ff[VW-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[RW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(RW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign root_ext = (RW + DIST_W)'(root_ff);
   assign root = (root_ext > (RW + DIST_W)'(DIST_MAX)) ? DIST_MAX : root_ext[DIST_W-1:0];
   assign done = done_ff;

endmodule

[design/pairwise_euclidean_distance_core.sv]
// Top level: row store, rotating chain of running sums, square root and control.
//
//  channel | direction | ports                                   | handshake
//  req     | in        | req_element_value                       | req_valid / req_ready
//  rsp     | out       | rsp_current_row, rsp_earlier_row,       | rsp_valid / rsp_ready
//          |           | rsp_distance, rsp_last_of_run           |
//  csr     | in        | csr_index, csr_wr_data                  | csr_wr_en, no wait
//
// For each element beat the sums of all MAX_ROWS cells rotate once past the head, one
// row-store read per cycle, behind a two-stage read/square pipe. A row end then rotates
// every cell past the head once more and takes a square root for each earlier row.
// Results wait in an output register; a stalled result holds the next root back.
// Reset is synchronous and clears control state only.
`timescale 1ns / 1ps
module pairwise_euclidean_distance_core
   import pwd_pkg::*;
#(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 1024
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [ELEM_W-1:0] req_element_value,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [OUT_ROW_W-1:0]     rsp_current_row,
   output logic [OUT_ROW_W-1:0]     rsp_earlier_row,
   output logic [DIST_W-1:0]        rsp_distance,
   output logic                     rsp_last_of_run,
   input  logic                     csr_wr_en,
   input  csr_index_type            csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_wr_data
);

   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ADDR_W = ROW_W + COL_W;
   localparam int SUM_W  = SQ_W + COL_W;
   localparam int COLS_CNT_W = ($clog2(MAX_COLS + 1) > COLS_REG_W) ?
                               $clog2(MAX_COLS + 1) : COLS_REG_W;
   localparam logic [ROW_W-1:0] LAST_J = ROW_W'(MAX_ROWS - 1);

   state_type state_ff, state_in;

   logic [ROWS_REG_W-1:0] rows_ff, rows_in;
   logic [COLS_CNT_W-1:0] cols_ff, cols_in;
   logic [ROW_W-1:0]      r_ff, r_in;
   logic [COL_W-1:0]      c_ff, c_in;
   logic [ROW_W-1:0]      cur_r_ff;
   logic [COL_W-1:0]      cur_c_ff;
   logic signed [ELEM_W-1:0] elem_ff;
   logic                  clr_ff;
   logic                  row_end_ff;
   logic [ROW_W-1:0]      j_ff, j_in;
   logic [ROW_W-1:0]      e_ff, e_in;

   logic                  s1_valid_ff;
   logic [ROW_W-1:0]      s1_j_ff;
   logic                  s2_valid_ff;
   logic [ROW_W-1:0]      s2_j_ff;
   logic [SQ_W-1:0]       s2_sq_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ROW_W-1:0]      rsp_cur_ff;
   logic [ROW_W-1:0]      rsp_j_ff;
   logic [DIST_W-1:0]     rsp_dist_ff;
   logic                  rsp_last_ff;

   logic                  accept;
   logic                  row_done;
   logic                  rd_en;
   logic signed [ELEM_W-1:0] rd_data;
   logic signed [ELEM_W:0]   diff;
   logic [ELEM_W:0]       diff_abs;
   logic [SQ_W-1:0]       sq;
   logic                  root_start;
   logic                  root_done;
   logic [DIST_W-1:0]     root_value;
   logic                  rsp_load;
   logic                  emit_shift;

   logic [SUM_W-1:0]      sums [MAX_ROWS];
   cell_op_type           tail_op;
   cell_op_type           pass_op;
   logic [SUM_W-1:0]      tail_addend;

   assign accept   = req_valid && req_ready;
   assign row_done = (int'(c_ff) + 1) >= int'(cols_ff);

   // Configuration writes, clamped into the legal range.
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROWS_IN_USE: begin
               if (csr_wr_data[ROWS_REG_W-1:0] < ROWS_REG_W'(2)) begin
                  rows_in = ROWS_REG_W'(2);
               end else if (int'(csr_wr_data[ROWS_REG_W-1:0]) > MAX_ROWS) begin
                  rows_in = ROWS_REG_W'(MAX_ROWS);
               end else begin
                  rows_in = csr_wr_data[ROWS_REG_W-1:0];
               end
            end
            CSR_COLUMNS_IN_USE: begin
               if (csr_wr_data[COLS_REG_W-1:0] == '0) begin
                  cols_in = COLS_CNT_W'(1);
               end else if (int'(csr_wr_data[COLS_REG_W-1:0]) > MAX_COLS) begin
                  cols_in = COLS_CNT_W'(MAX_COLS);
               end else begin
                  cols_in = COLS_CNT_W'(csr_wr_data[COLS_REG_W-1:0]);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      r_in = r_ff;
      c_in = c_ff;
      if (accept) begin
         if (row_done) begin
            c_in = '0;
            r_in = ((int'(r_ff) + 1) >= int'(rows_ff)) ? '0 : r_ff + 1'b1;
         end else begin
            c_in = c_ff + 1'b1;
         end
      end
   end

   // Control sequencer.
   always_comb begin
      state_in     = state_ff;
      j_in         = j_ff;
      e_in         = e_ff;
      req_ready    = 1'b0;
      rd_en        = 1'b0;
      root_start   = 1'b0;
      rsp_load     = 1'b0;
      emit_shift   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               j_in     = '0;
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            rd_en = 1'b1;
            j_in  = j_ff + 1'b1;
            if (j_ff == LAST_J) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (s2_valid_ff && s2_j_ff == LAST_J) begin
               e_in = '0;
               if (row_end_ff && cur_r_ff != '0) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            // Every cell passes the head once, whether or not it yields a result.
            emit_shift = 1'b1;
            if (e_ff < cur_r_ff) begin
               root_start = 1'b1;
               state_in   = ST_ROOT;
            end else if (e_ff == LAST_J) begin
               state_in = ST_IDLE;
            end else begin
               e_in = e_ff + 1'b1;
            end
         end
         ST_ROOT: begin
            if (root_done && (!rsp_valid_ff || rsp_ready)) begin
               rsp_load = 1'b1;
               e_in     = e_ff + 1'b1;
               state_in = ST_EMIT;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_ff      <= ROWS_REG_W'(MAX_ROWS);
         cols_ff      <= COLS_CNT_W'(MAX_COLS);
         r_ff         <= '0;
         c_ff         <= '0;
         j_ff         <= '0;
         e_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         r_ff         <= r_in;
         c_ff         <= c_in;
         j_ff         <= j_in;
         e_ff         <= e_in;
         s1_valid_ff  <= rd_en;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_r_ff   <= r_ff;
         cur_c_ff   <= c_ff;
         elem_ff    <= req_element_value;
         clr_ff     <= (c_ff == '0);
         row_end_ff <= row_done;
      end
      s1_j_ff  <= j_ff;
      s2_j_ff  <= s1_j_ff;
      s2_sq_ff <= sq;
      if (rsp_load) begin
         rsp_cur_ff  <= cur_r_ff;
         rsp_j_ff    <= e_ff;
         rsp_dist_ff <= root_value;
         rsp_last_ff <= (e_ff + 1'b1 == cur_r_ff);
      end
   end

   pwd_row_store #(
      .ADDR_W(ADDR_W)
   ) u_store (
      .clock  (clock),
      .wr_en  (accept),
      .wr_addr({r_ff, c_ff}),
      .wr_data(req_element_value),
      .rd_en  (rd_en),
      .rd_addr({j_ff, cur_c_ff}),
      .rd_data(rd_data)
   );

   // The absolute difference stays below 2**16, so its square fits in 32 bits.
   always_comb begin
      diff     = {elem_ff[ELEM_W-1], elem_ff} - {rd_data[ELEM_W-1], rd_data};
      diff_abs = diff[ELEM_W] ? (ELEM_W + 1)'(-diff) : diff;
      sq       = SQ_W'(diff_abs[ELEM_W-1:0]) * SQ_W'(diff_abs[ELEM_W-1:0]);
   end

   // The tail cell takes the head's sum, updated during a sweep; every other cell takes its neighbor's.
   always_comb begin
      tail_op.shift = s2_valid_ff || emit_shift;
      tail_op.clear = s2_valid_ff && clr_ff;
      tail_op.add   = s2_valid_ff && (s2_j_ff < cur_r_ff);
      pass_op.shift = s2_valid_ff || emit_shift;
      pass_op.clear = 1'b0;
      pass_op.add   = 1'b0;
      tail_addend   = SUM_W'(s2_sq_ff);
   end

   for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
      if (i == MAX_ROWS - 1) begin : g_tail
         pwd_sum_cell #(
            .SUM_W(SUM_W)
         ) u_cell (
            .clock (clock),
            .op    (tail_op),
            .nb_sum(sums[0]),
            .addend(tail_addend),
            .sum   (sums[i])
         );
      end else begin : g_body
         pwd_sum_cell #(
            .SUM_W(SUM_W)
         ) u_cell (
            .clock (clock),
            .op    (pass_op),
            .nb_sum(sums[i+1]),
            .addend(tail_addend),
            .sum   (sums[i])
         );
      end
   end

   pwd_isqrt #(
      .SUM_W(SUM_W)
   ) u_isqrt (
      .clock  (clock),
      .reset  (reset),
      .start  (root_start),
      .operand(sums[0]),
      .done   (root_done),
      .root   (root_value)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_current_row = OUT_ROW_W'(rsp_cur_ff);
   assign rsp_earlier_row = OUT_ROW_W'(rsp_j_ff);
   assign rsp_distance    = rsp_dist_ff;
   assign rsp_last_of_run = rsp_last_ff;

   a_last_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_run |-> rsp_current_row == rsp_earlier_row + 1'b1)
      else $error("last result of a row does not name the row just before it");

   a_lower_triangle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_earlier_row < rsp_current_row)
      else $error("result outside the lower triangle");

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again before the sweep");

   a_pipe_in_sweep: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> state_ff == ST_SWEEP || state_ff == ST_DRAIN)
      else $error("sum update outside a sweep");

endmodule

[verif/tb_pairwise_euclidean_distance_core.sv]
// Self-checking testbench for the pairwise Euclidean distance core.
`timescale 1ns / 1ps
module tb_pairwise_euclidean_distance_core;
   import pwd_pkg::*;

   localparam int MAX_ROWS = 64;
   localparam int MAX_COLS = 1024;
   localparam int SETTLE   = 400;

   typedef struct packed {
      logic [OUT_ROW_W-1:0] current_row;
      logic [OUT_ROW_W-1:0] earlier_row;
      logic [DIST_W-1:0]    distance;
      logic                 last_of_run;
   } distance_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [ELEM_W-1:0] req_element_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [OUT_ROW_W-1:0]     rsp_current_row;
   logic [OUT_ROW_W-1:0]     rsp_earlier_row;
   logic [DIST_W-1:0]        rsp_distance;
   logic                     rsp_last_of_run;
   logic                     csr_wr_en = 1'b0;
   csr_index_type            csr_index = CSR_ROWS_IN_USE;
   logic [CSR_DATA_W-1:0]    csr_wr_data = '0;

   pairwise_euclidean_distance_core #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_element_value(req_element_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_current_row(rsp_current_row),
      .rsp_earlier_row(rsp_earlier_row), .rsp_distance(rsp_distance),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   always #5 clock = ~clock;

   // Mirror of the block state.
   logic signed [ELEM_W-1:0] row_memory [MAX_ROWS*MAX_COLS];
   longint unsigned          squared_sums [MAX_ROWS];
   int                       cur_row_idx = 0;
   int                       cur_col_idx = 0;
   int                       rows_setting = MAX_ROWS;
   int                       cols_setting = MAX_COLS;

   logic signed [ELEM_W-1:0] element_queue [$];
   distance_result_type      pending_distances [$];
   int                       error_count = 0;
   int                       mismatch_count = 0;
   int                       elements_sent = 0;
   int                       distances_seen = 0;
   int                       settings_used = 0;
   bit                       calm = 1'b0;
   int                       send_gap = 0;
   int                       recv_stall = 0;

   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned res;
      longint unsigned trial;
      res = 0;
      for (int b = 22; b >= 0; b--) begin
         trial = res | (longint'(1) << b);
         if (trial * trial <= v) res = trial;
      end
      return res;
   endfunction

   function automatic void apply_element(logic signed [ELEM_W-1:0] x);
      int r;
      int c;
      int diff;
      longint unsigned root;
      distance_result_type res;
      r = cur_row_idx;
      c = cur_col_idx;
      if (c == 0)
         for (int j = 0; j < MAX_ROWS; j++) squared_sums[j] = 0;
      row_memory[r*MAX_COLS + c] = x;
      for (int j = 0; j < r; j++) begin
         diff = int'(x) - int'(row_memory[j*MAX_COLS + c]);
         squared_sums[j] += longint'(diff) * longint'(diff);
      end
      if (c + 1 >= cols_setting) begin
         for (int j = 0; j < r; j++) begin
            root = floor_root(squared_sums[j]);
            if (root > DIST_MAX) root = DIST_MAX;
            res.current_row = r[OUT_ROW_W-1:0];
            res.earlier_row = j[OUT_ROW_W-1:0];
            res.distance    = root[DIST_W-1:0];
            res.last_of_run = (j + 1 == r);
            pending_distances.push_back(res);
         end
         cur_col_idx = 0;
         cur_row_idx = (r + 1 >= rows_setting) ? 0 : r + 1;
      end else begin
         cur_col_idx = c + 1;
      end
   endfunction

   // Driver: one beat per handshake, random gaps between beats.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            apply_element(req_element_value);
            elements_sent++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (element_queue.size() > 0) begin
               req_valid         <= 1'b1;
               req_element_value <= element_queue.pop_front();
               if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 19);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compares each result beat with the oldest prediction.
   always @(posedge clock) begin
      distance_result_type got;
      distance_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_current_row, rsp_earlier_row, rsp_distance, rsp_last_of_run};
            distances_seen++;
            if (pending_distances.size() == 0) begin
               error_count++;
               $display("Unexpected result beat: row %0d vs %0d dist %0d",
                        got.current_row, got.earlier_row, got.distance);
            end else begin
               want = pending_distances.pop_front();
               if (got != want) begin
                  error_count++;
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"Mismatch: expected row %0d/%0d dist %0d last %0d, ",
                               "got %0d/%0d dist %0d last %0d"},
                              want.current_row, want.earlier_row, want.distance,
                              want.last_of_run, got.current_row, got.earlier_row,
                              got.distance, got.last_of_run);
               end
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            recv_stall = $urandom_range(0, 18);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic wait_idle();
      do begin
         @(posedge clock);
         #1;
      end while (element_queue.size() != 0 || req_valid || pending_distances.size() != 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      int v;
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_ROWS_IN_USE) begin
         v = value[ROWS_REG_W-1:0];
         rows_setting = (v < 2) ? 2 : (v > MAX_ROWS) ? MAX_ROWS : v;
      end else begin
         v = value;
         cols_setting = (v < 1) ? 1 : (v > MAX_COLS) ? MAX_COLS : v;
      end
      settings_used++;
   endtask

   function automatic logic signed [ELEM_W-1:0] pick_value(int style);
      case (style)
         0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         1: return ELEM_W'($urandom_range(0, 64) - 32);
         default: return ELEM_W'($urandom());
      endcase
   endfunction

   // Queues enough elements to bring the counters back to the start of a matrix.
   // A row at or past the row limit still completes, and then the count wraps.
   task automatic finish_matrix(int style);
      int row_left;
      int rows_left;
      row_left = cols_setting - cur_col_idx;
      if (row_left < 1) row_left = 1;
      rows_left = rows_setting - 1 - cur_row_idx;
      if (rows_left < 0) rows_left = 0;
      repeat (row_left + rows_left * cols_setting) element_queue.push_back(pick_value(style));
   endtask

   task automatic run_matrices(int count, int style);
      repeat (count) begin
         finish_matrix(style);
         wait_idle();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      // Directed: full-scale opposite rows, zeros and minus one.
      write_reg(CSR_ROWS_IN_USE, 11'd3);
      write_reg(CSR_COLUMNS_IN_USE, 11'd4);
      element_queue = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                        16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                        16'sh0000, -16'sd1, 16'sh0001, 16'sh7FFF};
      wait_idle();

      // Columns shrink in the middle of a row, then rows shrink below the current row.
      write_reg(CSR_ROWS_IN_USE, 11'd5);
      write_reg(CSR_COLUMNS_IN_USE, 11'd3);
      element_queue = '{16'sh0100, -16'sh0100, 16'sh1234, 16'sh7FFF, 16'sh8000};
      wait_idle();
      write_reg(CSR_COLUMNS_IN_USE, 11'd2);
      element_queue = '{16'sh0042, -16'sd7, 16'sh0003, 16'sh7F00, 16'sh00FF};
      wait_idle();
      write_reg(CSR_ROWS_IN_USE, 11'd2);
      run_matrices(1, 2);

      // Out-of-range writes clamp to the limits.
      write_reg(CSR_ROWS_IN_USE, 11'd0);
      write_reg(CSR_COLUMNS_IN_USE, 11'd0);
      run_matrices(2, 0);
      write_reg(CSR_ROWS_IN_USE, 11'h07F);
      write_reg(CSR_COLUMNS_IN_USE, 11'd1);
      run_matrices(1, 2);
      write_reg(CSR_ROWS_IN_USE, 11'h402);
      write_reg(CSR_COLUMNS_IN_USE, 11'h7FF);
      repeat (5) element_queue.push_back(pick_value(2));
      wait_idle();
      write_reg(CSR_COLUMNS_IN_USE, 11'd4);
      run_matrices(1, 2);

      // Random settings with small sizes.
      for (int p = 0; p < 6; p++) begin
         write_reg(CSR_ROWS_IN_USE, CSR_DATA_W'($urandom_range(2, 8)));
         write_reg(CSR_COLUMNS_IN_USE, CSR_DATA_W'($urandom_range(1, 4)));
         run_matrices(1, $urandom_range(0, 4));
      end

      calm = 1'b1;
      write_reg(CSR_ROWS_IN_USE, 11'd64);
      write_reg(CSR_COLUMNS_IN_USE, 11'd1);
      run_matrices(1, 2);

      $display("Sent %0d elements, checked %0d distances across %0d register writes.",
               elements_sent, distances_seen, settings_used);
      if (pending_distances.size() != 0) begin
         error_count++;
         $display("%0d predicted distances never arrived.", pending_distances.size());
      end
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d errors found.", error_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("Timeout with %0d distances outstanding.", pending_distances.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

[pairwise_euclidean_distance_core.f]
design/pwd_pkg.sv
design/pwd_row_store.sv
design/pwd_sum_cell.sv
design/pwd_isqrt.sv
design/pairwise_euclidean_distance_core.sv
verif/tb_pairwise_euclidean_distance_core.sv
